### hdl/angle_bracket_frame_receiver_unit_defines.svh
// assertion macros for the angle bracket frame receiver
`ifndef ANGLE_BRACKET_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define ANGLE_BRACKET_FRAME_RECEIVER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked on a given clock, off while reset is low
`define ABFR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// shorthand on the block clock and reset
`define ABFR_ASSERT(lbl, prop, msg) \
  `ABFR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define ABFR_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ABFR_ASSERT(lbl, prop, msg)
`endif

`endif

### hdl/abfr_pkg.sv
// shared constants, types and helpers of the angle bracket frame receiver
package abfr_pkg;

  localparam int unsigned PayloadDepthDefault = 10;

  localparam logic [7:0] StartMark = 8'h3C;
  localparam logic [7:0] EndMark   = 8'h0D;
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] MinusChar = 8'h2D;
  localparam logic [7:0] ZeroChar  = 8'h30;
  localparam logic [7:0] NineChar  = 8'h39;
  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] TabChar   = 8'h09;

  localparam logic [34:0] MagLimitPos = 35'd2147483647;
  localparam logic [34:0] MagLimitNeg = 35'd2147483648;

  localparam int unsigned OutDataW = 40;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PARSE = 3'b010,
    ST_DONE  = 3'b100
  } abfr_state_e;

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == SpaceChar) || ((c >= TabChar) && (c <= EndMark));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= ZeroChar) && (c <= NineChar);
  endfunction

endpackage

### hdl/angle_bracket_frame_receiver_unit.sv
// angle bracket frame receiver: payload memory, decimal parser, output register
// a plain byte or a start marker only updates the store or the selector, nothing is emitted
// a CR byte starts a walk over the payload memory, the parser taking the bytes in order:
// one read of the payload memory per cycle through its single read port
// throughput: one byte per cycle while idle; after a CR no byte is taken until its result is registered
// reset: asynchronous active low, store reads as zero via per-entry valid bits
`include "angle_bracket_frame_receiver_unit_defines.svh"

module angle_bracket_frame_receiver_unit #(
  parameter int unsigned PAYLOAD_DEPTH = abfr_pkg::PayloadDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [abfr_pkg::OutDataW-1:0] m_axis_tdata    // [7:0] option_byte, [39:8] parsed_value
);
  import abfr_pkg::*;

  localparam int unsigned PosW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [PosW-1:0] LastPos = PosW'(PAYLOAD_DEPTH - 1);

  abfr_state_e state_q, state_d;

  logic [PosW-1:0]          wpos_q;
  logic                     expect_sel_q;
  logic                     wrapped_q;
  logic [7:0]               sel_q;
  logic [PAYLOAD_DEPTH-1:0] vld_q;

  logic [7:0] mem_q [PAYLOAD_DEPTH];
  logic [7:0] rd_data_q;
  logic       rd_ok_q;

  logic [PosW-1:0] rd_addr_q;
  logic            issue_q;
  logic            rd_vld_q;
  logic            last_q;

  logic        seen_q;
  logic        stop_q;
  logic        neg_q;
  logic [31:0] mag_q;

  logic        out_valid_q;
  logic [7:0]  out_opt_q;
  logic [31:0] out_val_q;

  logic        in_fire;
  logic        is_start, is_end, is_store;
  logic [7:0]  cur_byte;
  logic [34:0] mag_ext, mag_limit, mag_step;
  logic [31:0] mag_sat;
  logic        take_digit, take_sign, now_stop;
  logic        out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_start      = (s_axis_tdata == StartMark);
  assign is_end        = (s_axis_tdata == EndMark);
  assign is_store      = in_fire && !is_start && !is_end && !expect_sel_q;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_val_q, out_opt_q};

  // byte under the parser, never-written entries read as zero
  assign cur_byte = rd_ok_q ? rd_data_q : 8'h00;

  always_comb begin
    take_digit = 1'b0;
    take_sign  = 1'b0;
    now_stop   = 1'b0;
    if (rd_vld_q && !stop_q) begin
      if (!seen_q) begin
        if (is_blank(cur_byte)) begin
          take_sign = 1'b0;
        end else if (cur_byte == PlusChar || cur_byte == MinusChar) begin
          take_sign = 1'b1;
        end else if (is_digit(cur_byte)) begin
          take_digit = 1'b1;
        end else begin
          now_stop = 1'b1;
        end
      end else if (is_digit(cur_byte)) begin
        take_digit = 1'b1;
      end else begin
        now_stop = 1'b1;
      end
    end
  end

  // mag * 10 + digit, clamped to the limit of the sign
  assign mag_ext   = 35'(mag_q);
  assign mag_limit = neg_q ? MagLimitNeg : MagLimitPos;
  assign mag_step  = (mag_ext << 3) + (mag_ext << 1) + 35'(cur_byte - ZeroChar);
  assign mag_sat   = (mag_step > mag_limit) ? mag_limit[31:0] : mag_step[31:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && is_end) begin
          state_d = ST_PARSE;
        end
      end
      ST_PARSE: begin
        if (last_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // payload memory, no reset
  always_ff @(posedge clk_i) begin
    if (is_store) begin
      mem_q[wpos_q] <= s_axis_tdata;
    end
    if (issue_q) begin
      rd_data_q <= mem_q[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wpos_q       <= '0;
      expect_sel_q <= 1'b0;
      wrapped_q    <= 1'b0;
      sel_q        <= 8'h00;
      vld_q        <= '0;
      rd_ok_q      <= 1'b0;
      rd_addr_q    <= '0;
      issue_q      <= 1'b0;
      rd_vld_q     <= 1'b0;
      last_q       <= 1'b0;
      seen_q       <= 1'b0;
      stop_q       <= 1'b0;
      neg_q        <= 1'b0;
      mag_q        <= '0;
      out_valid_q  <= 1'b0;
      out_opt_q    <= 8'h00;
      out_val_q    <= '0;
    end else begin
      state_q <= state_d;

      if (in_fire) begin
        if (is_start) begin
          wpos_q       <= '0;
          expect_sel_q <= 1'b1;
          wrapped_q    <= 1'b0;
        end else if (is_end) begin
          // zero fill of the unwritten tail
          if (!wrapped_q) begin
            for (int k = 0; k < PAYLOAD_DEPTH; k++) begin
              if (PosW'(k) >= wpos_q) begin
                vld_q[k] <= 1'b0;
              end
            end
          end
          rd_addr_q <= '0;
          issue_q   <= 1'b1;
          seen_q    <= 1'b0;
          stop_q    <= 1'b0;
          neg_q     <= 1'b0;
          mag_q     <= '0;
        end else if (expect_sel_q) begin
          sel_q        <= s_axis_tdata;
          expect_sel_q <= 1'b0;
        end else begin
          vld_q[wpos_q] <= 1'b1;
          if (wpos_q == LastPos) begin
            wpos_q    <= '0;
            wrapped_q <= 1'b1;
          end else begin
            wpos_q <= wpos_q + 1'b1;
          end
        end
      end

      // read walk over the store
      if (issue_q) begin
        rd_ok_q <= vld_q[rd_addr_q];
        if (rd_addr_q == LastPos) begin
          issue_q <= 1'b0;
        end else begin
          rd_addr_q <= rd_addr_q + 1'b1;
        end
      end
      rd_vld_q <= issue_q;
      last_q   <= issue_q && (rd_addr_q == LastPos);

      if (take_sign) begin
        seen_q <= 1'b1;
        neg_q  <= (cur_byte == MinusChar);
      end
      if (take_digit) begin
        seen_q <= 1'b1;
        mag_q  <= mag_sat;
      end
      if (now_stop) begin
        stop_q <= 1'b1;
      end

      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
        out_opt_q   <= sel_q;
        out_val_q   <= neg_q ? (32'd0 - mag_q) : mag_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `ABFR_ASSERT(a_no_accept_in_walk, s_axis_tready |-> (!issue_q && !rd_vld_q && !last_q), "byte accepted during payload walk")
  `ABFR_ASSERT(a_cr_starts_walk, (in_fire && is_end) |=> (state_q == ST_PARSE && issue_q && rd_addr_q == '0), "CR did not start the walk")
  `ABFR_ASSERT(a_result_from_done, $rose(m_axis_tvalid) |-> ($past(state_q) == ST_DONE), "result raised outside done")
  `ABFR_ASSERT_CLK(a_last_ends_issue, clk_i, rst_ni, last_q |-> (!issue_q && rd_vld_q), "walk end out of order")

endmodule

### tb/angle_bracket_frame_receiver_unit_tb.sv
// testbench for the angle bracket frame receiver: directed and random framed byte streams against a scoreboard
import abfr_pkg::*;

typedef struct packed {
  logic signed [31:0] parsed_value;
  logic [7:0]         option_byte;
} frame_result_t;

class frame_scoreboard;
  localparam int unsigned Depth = PayloadDepthDefault;

  logic [7:0]    payload_mem [Depth];
  logic [3:0]    wr_pos;
  bit            awaiting_selector;
  bit            store_wrapped;
  logic [7:0]    selector_byte;
  frame_result_t expected_frames[$];
  int unsigned   mismatches;

  function new();
    foreach (payload_mem[k]) payload_mem[k] = '0;
    wr_pos            = '0;
    awaiting_selector = 1'b0;
    store_wrapped     = 1'b0;
    selector_byte     = '0;
    mismatches        = 0;
  endfunction

  function bit char_is_space(logic [7:0] c);
    return (c == SpaceChar) || (c >= TabChar && c <= EndMark);
  endfunction

  // strtol style walk over the whole store, saturating on the magnitude
  function logic signed [31:0] decode_payload();
    int unsigned k;
    bit          neg;
    logic [34:0] mag;
    logic [34:0] cap;
    k   = 0;
    neg = 1'b0;
    mag = '0;
    while (k < Depth && char_is_space(payload_mem[k])) k++;
    if (k < Depth && (payload_mem[k] == PlusChar || payload_mem[k] == MinusChar)) begin
      neg = (payload_mem[k] == MinusChar);
      k++;
    end
    cap = neg ? MagLimitNeg : MagLimitPos;
    while (k < Depth && payload_mem[k] >= ZeroChar && payload_mem[k] <= NineChar) begin
      mag = mag * 35'd10 + 35'(payload_mem[k] - ZeroChar);
      if (mag > cap) mag = cap;
      k++;
    end
    return neg ? -mag[31:0] : mag[31:0];
  endfunction

  function void note_byte(logic [7:0] b);
    frame_result_t r;
    int unsigned   k;
    if (b == StartMark) begin
      wr_pos            = '0;
      awaiting_selector = 1'b1;
      store_wrapped     = 1'b0;
    end else if (b == EndMark) begin
      if (!store_wrapped)
        for (k = wr_pos; k < Depth; k++) payload_mem[k] = '0;
      r.option_byte  = selector_byte;
      r.parsed_value = decode_payload();
      expected_frames.push_back(r);
    end else if (awaiting_selector) begin
      selector_byte     = b;
      awaiting_selector = 1'b0;
    end else begin
      payload_mem[wr_pos] = b;
      if (wr_pos == Depth - 1) begin
        wr_pos        = '0;
        store_wrapped = 1'b1;
      end else begin
        wr_pos++;
      end
    end
  endfunction

  function void report(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d got %0d", what, want, got);
  endfunction

  function void check_result(logic [39:0] data);
    frame_result_t got;
    frame_result_t want;
    got = data;
    if (expected_frames.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: option_byte %02h parsed_value %0d",
                 got.option_byte, got.parsed_value);
      return;
    end
    want = expected_frames.pop_front();
    if (got.option_byte !== want.option_byte)
      report("option_byte", want.option_byte, got.option_byte);
    if (got.parsed_value !== want.parsed_value)
      report("parsed_value", want.parsed_value, got.parsed_value);
  endfunction
endclass

module angle_bracket_frame_receiver_unit_tb;
  localparam int unsigned PAYLOAD_DEPTH = PayloadDepthDefault;
  localparam int unsigned CycleLimit    = 500000;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;   // [7:0] rx_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // [7:0] option_byte, [39:8] parsed_value

  frame_scoreboard sb;
  int unsigned     send_idle_pct   = 0;
  int unsigned     recv_stall_pct  = 0;
  int unsigned     hold_off_cycles = 0;
  int unsigned     items_sent      = 0;
  int unsigned     cycle_count     = 0;
  int unsigned     idle_plan[4]    = '{0, 66, 0, 9};
  int unsigned     stall_plan[4]   = '{0, 0, 66, 9};

  angle_bracket_frame_receiver_unit #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver side: long hold-off when asked, random stalls otherwise
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      m_axis_tready   <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] random_selector();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == StartMark || c == EndMark) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] random_blank();
    int unsigned k;
    k = $urandom_range(4);
    return (k == 4) ? SpaceChar : TabChar + 8'(k);
  endfunction

  function automatic logic [7:0] random_digit();
    return ZeroChar + 8'($urandom_range(9));
  endfunction

  task automatic send_random_frame();
    logic [7:0]  seq[$];
    int unsigned shape;
    int unsigned n;
    shape = $urandom_range(99);
    if (shape < 80) begin
      // well formed frame with a number-like payload
      seq.push_back(StartMark);
      seq.push_back(random_selector());
      repeat ($urandom_range(2)) seq.push_back(random_blank());
      if ($urandom_range(2) == 0) seq.push_back($urandom_range(1) ? MinusChar : PlusChar);
      n = ($urandom_range(9) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 7);
      repeat (n) seq.push_back(random_digit());
      if ($urandom_range(3) == 0) seq.push_back(random_selector());
      seq.push_back(EndMark);
    end else if (shape < 90) begin
      // CR keeps the write position, so the next run continues the store
      seq.push_back(StartMark);
      if ($urandom_range(1)) seq.push_back(random_selector());
      repeat ($urandom_range(0, 4)) seq.push_back(random_digit());
      seq.push_back(EndMark);
      repeat ($urandom_range(0, 6)) seq.push_back(random_digit());
      seq.push_back(EndMark);
    end else begin
      repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom_range(255)));
      if ($urandom_range(1)) seq.push_back(EndMark);
    end
    foreach (seq[k]) send_byte(seq[k]);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_frames.size() != 0) @(negedge clk_i);
    repeat (PAYLOAD_DEPTH + 8) @(negedge clk_i);
  endtask

  initial begin
    logic [7:0]  directed_seq[$];
    int unsigned goal;
    int unsigned phase;
    sb = new();
    directed_seq = '{
      EndMark,                                  // result straight out of reset
      8'h34, 8'h32, EndMark,                    // payload before any start marker
      StartMark, EndMark,                       // CR while the selector is awaited
      8'hFF,                                    // selector still awaited, takes this
      NineChar, NineChar, NineChar, NineChar, NineChar,
      NineChar, NineChar, NineChar, NineChar, NineChar,
      EndMark,                                  // full store wraps, saturates high
      StartMark, PlusChar, SpaceChar, MinusChar, 8'h37, 8'h80, 8'h33, EndMark
    };
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_seq[k]) send_byte(directed_seq[k]);

    // output side blocked while frames keep coming, input must back up
    hold_off_cycles = 400;
    goal = items_sent + 60;
    while (items_sent < goal) send_random_frame();
    wait_for_results();

    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_plan[phase];
      recv_stall_pct = stall_plan[phase];
      goal = items_sent + 280;
      while (items_sent < goal) send_random_frame();
      wait_for_results();
    end

    if (sb.mismatches == 0 && sb.expected_frames.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
